[hw/rtl/usb_packet_decoder_unit_macros.svh]
// assertion macros shared by the usb packet decoder rtl
`ifndef USB_PACKET_DECODER_UNIT_MACROS_SVH
`define USB_PACKET_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define UPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/upd_pkg.sv]
// types, constants and crc helpers for the usb packet decoder
package upd_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [10:0] CNT_MAX = 11'h7FF;

    // full pid bytes, check nibble included
    localparam logic [7:0] PID_OUT   = 8'hE1;
    localparam logic [7:0] PID_IN    = 8'h69;
    localparam logic [7:0] PID_SOF   = 8'hA5;
    localparam logic [7:0] PID_SETUP = 8'h2D;
    localparam logic [7:0] PID_DATA0 = 8'hC3;
    localparam logic [7:0] PID_DATA1 = 8'h4B;
    localparam logic [7:0] PID_ACK   = 8'hD2;
    localparam logic [7:0] PID_NAK   = 8'h5A;
    localparam logic [7:0] PID_STALL = 8'h1E;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SHORT       = 2'd1;
    localparam logic [1:0] ST_UNKNOWN_PID = 2'd2;
    localparam logic [1:0] ST_OVERSIZE    = 2'd3;

    localparam logic [1:0] KIND_TOKEN     = 2'd0;
    localparam logic [1:0] KIND_DATA      = 2'd1;
    localparam logic [1:0] KIND_HANDSHAKE = 2'd2;

    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'hA001;
    localparam logic [4:0]  CRC5_INIT  = 5'h1F;
    localparam logic [4:0]  CRC5_POLY  = 5'h14;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  packet_kind;
        logic [7:0]  pid_value;
        logic [6:0]  device_address;
        logic [3:0]  endpoint_number;
        logic [10:0] payload_length;
        logic        crc_ok;
    } result_t;

    // what the front hands over at the end of a packet
    typedef struct packed {
        logic [7:0]  pid;
        logic [10:0] len;
        logic [7:0]  token_low;
        logic [7:0]  token_high;
        logic [4:0]  crc5_part;
        logic [15:0] crc16;
        logic [7:0]  tail_new;
        logic [7:0]  tail_old;
    } pkt_summary_t;

    // reflected crc-16, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] c_in,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC16_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // reflected crc-5 over the eight low token bits
    function automatic logic [4:0] crc5_byte(input logic [4:0] c_in,
                                             input logic [7:0] b);
        logic [4:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC5_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // last three token bits, then complement
    function automatic logic [4:0] crc5_finish(input logic [4:0] c_in,
                                               input logic [2:0] b);
        logic [4:0] c;
        c = c_in;
        for (int k = 0; k < 3; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC5_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c ^ CRC5_INIT;
    endfunction

endpackage

[hw/rtl/upd_front.sv]
// front end: takes packet beats, keeps per-packet state, emits a summary
`include "usb_packet_decoder_unit_macros.svh"

module upd_front
    import upd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_beat_t     s_data,
    input  logic         q_full,
    output logic         push,
    output pkt_summary_t summary
);

    logic [10:0] count_reg, count_next, count_upd;
    logic [7:0]  first_reg, first_next, first_upd;
    logic [7:0]  tok_lo_reg, tok_lo_next, tok_lo_upd;
    logic [7:0]  tok_hi_reg, tok_hi_next, tok_hi_upd;
    logic [4:0]  crc5_reg, crc5_next, crc5_upd;
    logic [15:0] crc16_reg, crc16_next, crc16_upd;
    logic [7:0]  tail0_reg, tail0_next, tail0_upd;
    logic [7:0]  tail1_reg, tail1_next, tail1_upd;
    logic        beat;

    assign s_ready = !q_full;
    assign beat    = s_valid && s_ready;
    assign push    = beat && s_data.last_byte;

    always_comb begin
        count_upd = count_reg;
        first_upd = first_reg;
        tok_lo_upd = tok_lo_reg;
        tok_hi_upd = tok_hi_reg;
        crc5_upd = crc5_reg;
        crc16_upd = crc16_reg;
        tail0_upd = tail0_reg;
        tail1_upd = tail1_reg;
        if (beat) begin
            if (count_reg == 11'd0) begin
                first_upd = s_data.byte_value;
            end
            if (count_reg == 11'd1) begin
                tok_lo_upd = s_data.byte_value;
                crc5_upd = crc5_byte(CRC5_INIT, s_data.byte_value);
            end
            if (count_reg == 11'd2) begin
                tok_hi_upd = s_data.byte_value;
            end
            if (count_reg != 11'd0) begin
                tail1_upd = tail0_reg;
                tail0_upd = s_data.byte_value;
            end
            // the byte leaving the tail line joins the sum
            if (count_reg >= 11'd3) begin
                crc16_upd = crc16_update(crc16_reg, tail1_reg);
            end
            if (count_reg != CNT_MAX) begin
                count_upd = count_reg + 11'd1;
            end
        end
    end

    always_comb begin
        summary.pid        = first_upd;
        summary.len        = count_upd;
        summary.token_low  = tok_lo_upd;
        summary.token_high = tok_hi_upd;
        summary.crc5_part  = crc5_upd;
        summary.crc16      = crc16_upd;
        summary.tail_new   = tail0_upd;
        summary.tail_old   = tail1_upd;
    end

    always_comb begin
        if (push) begin
            count_next = '0;
            first_next = '0;
            tok_lo_next = '0;
            tok_hi_next = '0;
            crc5_next = CRC5_INIT;
            crc16_next = CRC16_INIT;
            tail0_next = '0;
            tail1_next = '0;
        end else begin
            count_next = count_upd;
            first_next = first_upd;
            tok_lo_next = tok_lo_upd;
            tok_hi_next = tok_hi_upd;
            crc5_next = crc5_upd;
            crc16_next = crc16_upd;
            tail0_next = tail0_upd;
            tail1_next = tail1_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            first_reg <= '0;
            tok_lo_reg <= '0;
            tok_hi_reg <= '0;
            crc5_reg <= CRC5_INIT;
            crc16_reg <= CRC16_INIT;
            tail0_reg <= '0;
            tail1_reg <= '0;
        end else begin
            count_reg <= count_next;
            first_reg <= first_next;
            tok_lo_reg <= tok_lo_next;
            tok_hi_reg <= tok_hi_next;
            crc5_reg <= crc5_next;
            crc16_reg <= crc16_next;
            tail0_reg <= tail0_next;
            tail1_reg <= tail1_next;
        end
    end

    `UPD_ASSERT_NEXT(a_front_clear_after_last, push, (count_reg == 11'd0) && (crc16_reg == CRC16_INIT), "packet state not cleared after last beat")
    `UPD_ASSERT_IMPL(a_front_crc_idle_early, (count_reg < 11'd4), (crc16_reg == CRC16_INIT), "crc moved before payload")

endmodule

[hw/rtl/upd_queue.sv]
// short queue of packet summaries between front and back
`include "usb_packet_decoder_unit_macros.svh"

module upd_queue
    import upd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  pkt_summary_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output pkt_summary_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pkt_summary_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `UPD_ASSERT_IMPL(a_queue_no_overflow, push, !full, "push into full queue")
    `UPD_ASSERT_IMPL(a_queue_no_underflow, pop, head_valid, "pop from empty queue")
    `UPD_ASSERT_IMPL(a_queue_count_range, 1'b1, (cnt_reg <= CNT_W'(QUEUE_DEPTH)), "queue count out of range")

endmodule

[hw/rtl/upd_back.sv]
// back end: decodes a packet summary into a result and holds it for the sink
`include "usb_packet_decoder_unit_macros.svh"

module upd_back
    import upd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         head_valid,
    input  pkt_summary_t head,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output result_t      m_data
);

    result_t     res;
    result_t     m_data_reg;
    logic        m_valid_reg, m_valid_next;
    logic [10:0] plen;

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign plen    = head.len - 11'd3;

    always_comb begin
        res = '0;
        res.pid_value = head.pid;
        unique case (head.pid)
            PID_OUT, PID_IN, PID_SOF, PID_SETUP: begin
                res.packet_kind = KIND_TOKEN;
                if (head.len < 11'd3) begin
                    res.status = ST_SHORT;
                end else begin
                    res.device_address = head.token_low[6:0];
                    res.endpoint_number = {head.token_high[2:0], head.token_low[7]};
                    res.crc_ok = (crc5_finish(head.crc5_part, head.token_high[2:0])
                                  == head.token_high[7:3]);
                end
            end
            PID_DATA0, PID_DATA1: begin
                res.packet_kind = KIND_DATA;
                if (head.len < 11'd3) begin
                    res.status = ST_SHORT;
                end else if (plen > 11'(MAX_PAYLOAD)) begin
                    res.status = ST_OVERSIZE;
                end else begin
                    res.payload_length = plen;
                    // crc arrives low byte first, so the newest byte is the high one
                    res.crc_ok = (plen == 11'd0)
                                 || ({head.tail_new, head.tail_old} == ~head.crc16);
                end
            end
            PID_ACK, PID_NAK, PID_STALL: begin
                res.packet_kind = KIND_HANDSHAKE;
                res.crc_ok = 1'b1;
            end
            default: begin
                res.status = ST_UNKNOWN_PID;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= res;
        end
    end

    `UPD_ASSERT_IMPL(a_back_oversize_clean, m_valid_reg && (m_data_reg.status == ST_OVERSIZE), (m_data_reg.payload_length == 11'd0) && !m_data_reg.crc_ok, "oversize result carries payload fields")
    `UPD_ASSERT_IMPL(a_back_length_bound, m_valid_reg, (m_data_reg.payload_length <= 11'(MAX_PAYLOAD)), "payload length above limit")
    `UPD_ASSERT_IMPL(a_back_unknown_clean, m_valid_reg && (m_data_reg.status == ST_UNKNOWN_PID), (m_data_reg.packet_kind == KIND_TOKEN) && !m_data_reg.crc_ok, "unknown pid result not cleared")

endmodule

[hw/rtl/usb_packet_decoder_unit.sv]
// top level of the usb packet decoder: front end, summary queue, back end
//
// The decoder takes one usb packet byte per beat on the s_ channel, pid byte
// first, with last_byte set on the final byte, and gives exactly one result
// beat on the m_ channel per packet: status, packet kind, raw pid, token
// address and endpoint, data payload length and crc validity. One byte is
// taken every clock cycle while the summary queue is not full; the running
// crc-16 is a byte-wide update that settles within that cycle, so packets can
// follow each other with no gap. A result passes through the summary queue
// and then the decode register before it appears on m_valid.
// The queue holds two packet summaries; s_ready drops only when it is full,
// which happens only while the sink holds m_ready low. The data crc covers
// just the payload: the two newest bytes sit in a tail line and are compared
// against the complemented crc at the end. Token crc-5 is split between the
// front (eight address/endpoint bits) and the back (last three bits).

module usb_packet_decoder_unit
    import upd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    // summary handover from the front
    logic         push;
    pkt_summary_t summary;
    logic         q_full;

    // queue head towards the back
    logic         head_valid;
    pkt_summary_t head;
    logic         pop;

    // front: byte accounting, pid and token capture, crc-16 and tail line
    upd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push),
        .summary (summary)
    );

    // decouples byte intake from result delivery
    upd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (summary),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: classification, crc checks, registered result beat
    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
